>>> src/ckc_pkg.sv
// ----------------------------------------------------------------------------
// ckc_pkg
// Shared constants, the keyword table and the command item passed from the
// lexer to the count unit.
// ----------------------------------------------------------------------------
package ckc_pkg;

  localparam int NUM_KEYS           = 32;
  localparam int KEY_IDX_W          = 5;
  localparam int KEY_MAX_LEN        = 8;
  localparam int DEF_MAX_WORD_CHARS = 8;
  localparam int DEF_COUNT_BITS     = 16;
  localparam int TOTAL_W            = 16;
  localparam int QUEUE_DEPTH        = 4;

  localparam logic [1:0] MODE_NORMAL  = 2'd0;
  localparam logic [1:0] MODE_STRING  = 2'd1;
  localparam logic [1:0] MODE_COMMENT = 2'd2;
  localparam logic [1:0] MODE_PREP    = 2'd3;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_UNDER = 8'h5f;

  // keywords in alphabetical order, right-justified, zero padded
  localparam logic [63:0] KEY_TEXT [NUM_KEYS] = '{
    "auto", "break", "case", "char", "const", "continue", "default", "do",
    "double", "else", "enum", "extern", "float", "for", "goto", "if",
    "int", "long", "register", "return", "short", "signed", "sizeof", "static",
    "struct", "switch", "typedef", "union", "unsigned", "void", "volatile", "while"
  };

  typedef struct packed {
    logic                 is_end;
    logic                 hit;
    logic [KEY_IDX_W-1:0] idx;
    logic [1:0]           mode;
  } cmd_t;

  function automatic logic [3:0] key_len(input logic [KEY_IDX_W-1:0] k);
    logic [63:0] w;
    logic [3:0]  n;
    w = KEY_TEXT[k];
    n = 4'd0;
    for (int j = 0; j < KEY_MAX_LEN; j++) begin
      if (w[8*j +: 8] != 8'h00) n = n + 4'd1;
    end
    return n;
  endfunction

  function automatic logic [7:0] key_char(input logic [KEY_IDX_W-1:0] k,
                                          input logic [2:0] i);
    logic [63:0] w;
    int          l;
    int          pos;
    w   = KEY_TEXT[k];
    l   = int'(key_len(k));
    pos = 0;
    if (int'(i) < l) begin
      pos = 8 * (l - 1 - int'(i));
      return w[pos +: 8];
    end
    return 8'h00;
  endfunction

endpackage

>>> src/ckc_lexer.sv
// ----------------------------------------------------------------------------
// ckc_lexer
// Front end: takes characters, tracks string, comment and preprocessor
// modes, collects words and matches a finished word against the keywords.
// ----------------------------------------------------------------------------
module ckc_lexer #(
  parameter int MAX_WORD_CHARS = ckc_pkg::DEF_MAX_WORD_CHARS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   ch,
  input  logic         end_of_text,
  input  logic         q_full,
  output logic         q_push,
  output ckc_pkg::cmd_t q_data
);

  localparam int WL_W  = $clog2(MAX_WORD_CHARS + 1);
  localparam int IDX_W = $clog2(MAX_WORD_CHARS);

  typedef enum logic [3:0] {
    LX_NORMAL  = 4'b0001,
    LX_STRING  = 4'b0010,
    LX_COMMENT = 4'b0100,
    LX_PREP    = 4'b1000
  } lex_state_t;

  lex_state_t      state, state_next;
  logic            mark, mark_next;
  logic [WL_W-1:0] wlen, wlen_next;
  logic            too_long, too_long_next;
  logic [7:0]      word_buf [MAX_WORD_CHARS];

  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic             flush;
  logic             is_letter, is_word;
  logic [ckc_pkg::NUM_KEYS-1:0]  match;
  logic [ckc_pkg::KEY_IDX_W-1:0] match_idx;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  assign is_letter = (ch >= 8'h61 && ch <= 8'h7a) || (ch >= 8'h41 && ch <= 8'h5a);
  assign is_word   = is_letter || (ch >= 8'h30 && ch <= 8'h39) || ch == ckc_pkg::CH_UNDER;

  // parallel compare of the pending word with every keyword
  always_comb begin
    logic [ckc_pkg::KEY_IDX_W-1:0] kk;
    match_idx = '0;
    for (int k = 0; k < ckc_pkg::NUM_KEYS; k++) begin
      kk       = ckc_pkg::KEY_IDX_W'(k);
      match[k] = (wlen == WL_W'(ckc_pkg::key_len(kk)));
      for (int i = 0; i < ckc_pkg::KEY_MAX_LEN; i++) begin
        if (i < int'(ckc_pkg::key_len(kk))) begin
          match[k] = match[k] && (word_buf[i] == ckc_pkg::key_char(kk, 3'(i)));
        end
      end
      if (match[k]) match_idx = kk;
    end
  end

  function automatic logic [1:0] mode_code(input lex_state_t s);
    logic [1:0] m;
    unique case (s)
      LX_NORMAL:  m = ckc_pkg::MODE_NORMAL;
      LX_STRING:  m = ckc_pkg::MODE_STRING;
      LX_COMMENT: m = ckc_pkg::MODE_COMMENT;
      LX_PREP:    m = ckc_pkg::MODE_PREP;
      default:    m = ckc_pkg::MODE_NORMAL;
    endcase
    return m;
  endfunction

  always_comb begin
    state_next    = state;
    mark_next     = mark;
    wlen_next     = wlen;
    too_long_next = too_long;
    wr_en         = 1'b0;
    wr_idx        = '0;
    flush         = 1'b0;

    if (end_of_text) begin
      flush         = (wlen != '0);
      wlen_next     = '0;
      too_long_next = 1'b0;
      mark_next     = 1'b0;
    end else begin
      if (state == LX_NORMAL && wlen != '0 && is_word) begin
        if (wlen < WL_W'(MAX_WORD_CHARS)) begin
          wr_en     = 1'b1;
          wr_idx    = wlen[IDX_W-1:0];
          wlen_next = wlen + WL_W'(1);
        end else begin
          too_long_next = 1'b1;
        end
      end else begin
        flush         = (wlen != '0);
        wlen_next     = '0;
        too_long_next = 1'b0;
        if (state == LX_NORMAL && is_letter) begin
          wr_en     = 1'b1;
          wr_idx    = '0;
          wlen_next = WL_W'(1);
        end
      end

      unique case (state)
        LX_NORMAL: begin
          if (mark && ch == ckc_pkg::CH_STAR) begin
            state_next = LX_COMMENT;
            mark_next  = 1'b0;
          end else begin
            if (ch == ckc_pkg::CH_QUOTE) state_next = LX_STRING;
            else if (ch == ckc_pkg::CH_HASH) state_next = LX_PREP;
            mark_next = (ch == ckc_pkg::CH_SLASH);
          end
        end
        LX_STRING: begin
          if (ch == ckc_pkg::CH_QUOTE) state_next = LX_NORMAL;
          mark_next = 1'b0;
        end
        LX_COMMENT: begin
          if (mark && ch == ckc_pkg::CH_SLASH) begin
            state_next = LX_NORMAL;
            mark_next  = 1'b0;
          end else begin
            mark_next = (ch == ckc_pkg::CH_STAR);
          end
        end
        LX_PREP: begin
          if (ch == ckc_pkg::CH_NL) state_next = LX_NORMAL;
          mark_next = 1'b0;
        end
        default: begin
          state_next = LX_NORMAL;
          mark_next  = 1'b0;
        end
      endcase
    end

    q_data.is_end = end_of_text;
    q_data.hit    = flush && !too_long && (|match);
    q_data.idx    = q_data.hit ? match_idx : '0;
    q_data.mode   = mode_code(state_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= LX_NORMAL;
      mark     <= 1'b0;
      wlen     <= '0;
      too_long <= 1'b0;
    end else if (accept) begin
      state    <= state_next;
      mark     <= mark_next;
      wlen     <= wlen_next;
      too_long <= too_long_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) word_buf[wr_idx] <= ch;
  end

endmodule

>>> src/ckc_queue.sv
// ----------------------------------------------------------------------------
// ckc_queue
// Short first-in first-out queue of commands between lexer and count unit.
// ----------------------------------------------------------------------------
module ckc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ckc_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output ckc_pkg::cmd_t pop_data,
  output logic          empty
);

  localparam int PTR_W = $clog2(ckc_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(ckc_pkg::QUEUE_DEPTH + 1);

  ckc_pkg::cmd_t    slots [ckc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full     = (fill == CNT_W'(ckc_pkg::QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop && !empty) rd_ptr <= rd_ptr + PTR_W'(1);
      priority if ((push && !full) && !(pop && !empty)) fill <= fill + CNT_W'(1);
      else if (!(push && !full) && (pop && !empty)) fill <= fill - CNT_W'(1);
      else fill <= fill;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_data;
  end

endmodule

>>> src/ckc_tally.sv
// ----------------------------------------------------------------------------
// ckc_tally
// Back end: updates the saturating keyword counts, drives the result
// register and walks the count table for a report.
// ----------------------------------------------------------------------------
module ckc_tally #(
  parameter int COUNT_BITS = ckc_pkg::DEF_COUNT_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  ckc_pkg::cmd_t q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          kind,
  output logic          keyword_hit,
  output logic [ckc_pkg::KEY_IDX_W-1:0] keyword_index,
  output logic [ckc_pkg::TOTAL_W-1:0]   keyword_total,
  output logic [1:0]    lex_mode,
  output logic          last
);

  localparam int TOT_W = (COUNT_BITS > ckc_pkg::TOTAL_W) ? COUNT_BITS : ckc_pkg::TOTAL_W;

  typedef enum logic [1:0] {
    ST_RUN    = 2'b01,
    ST_REPORT = 2'b10
  } tally_state_t;

  tally_state_t state;
  logic [COUNT_BITS-1:0]         counts [ckc_pkg::NUM_KEYS];
  logic [ckc_pkg::KEY_IDX_W-1:0] rep_idx;
  logic                          rep_hit;
  logic [ckc_pkg::KEY_IDX_W-1:0] rep_hit_idx;
  logic [1:0]                    rep_mode;

  logic                          out_load;
  logic [ckc_pkg::KEY_IDX_W-1:0] rd_addr;
  logic [COUNT_BITS-1:0]         rd_val, inc_val;
  logic [TOT_W-1:0]              tot_ext;
  logic                          rep_last;

  assign out_load = !out_valid || out_ready;
  assign q_pop    = (state == ST_RUN) && !q_empty && out_load;
  assign rd_addr  = (state == ST_REPORT) ? rep_idx : q_data.idx;
  assign rd_val   = counts[rd_addr];
  assign inc_val  = (&rd_val) ? rd_val : rd_val + COUNT_BITS'(1);
  assign rep_last = (rep_idx == ckc_pkg::KEY_IDX_W'(ckc_pkg::NUM_KEYS - 1));

  always_comb begin
    tot_ext = '0;
    if (state == ST_REPORT) tot_ext = TOT_W'(rd_val);
    else if (q_data.hit)    tot_ext = TOT_W'(inc_val);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      out_valid <= 1'b0;
      rep_idx   <= '0;
      for (int k = 0; k < ckc_pkg::NUM_KEYS; k++) counts[k] <= '0;
    end else begin
      if (q_pop && q_data.hit) counts[q_data.idx] <= inc_val;
      unique case (state)
        ST_RUN: begin
          if (q_pop) begin
            if (q_data.is_end) begin
              state     <= ST_REPORT;
              rep_idx   <= '0;
              out_valid <= 1'b0;
            end else begin
              out_valid <= 1'b1;
            end
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        ST_REPORT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            rep_idx   <= rep_idx + ckc_pkg::KEY_IDX_W'(1);
            if (rep_last) state <= ST_RUN;
          end
        end
        default: begin
          state     <= ST_RUN;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.is_end) begin
      rep_hit     <= q_data.hit;
      rep_hit_idx <= q_data.idx;
      rep_mode    <= q_data.mode;
    end
    if (q_pop && !q_data.is_end) begin
      kind          <= ckc_pkg::KIND_STATUS;
      keyword_hit   <= q_data.hit;
      keyword_index <= q_data.idx;
      keyword_total <= tot_ext[ckc_pkg::TOTAL_W-1:0];
      lex_mode      <= q_data.mode;
      last          <= 1'b1;
    end else if (state == ST_REPORT && out_load) begin
      kind          <= ckc_pkg::KIND_REPORT;
      keyword_hit   <= rep_hit && (rep_hit_idx == rep_idx);
      keyword_index <= rep_idx;
      keyword_total <= tot_ext[ckc_pkg::TOTAL_W-1:0];
      lex_mode      <= rep_mode;
      last          <= rep_last;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_in_report: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPORT) |-> !q_pop)
    else $error("command taken during report");

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == ckc_pkg::KIND_STATUS) |-> last)
    else $error("status result without last");

  a_hit_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == ckc_pkg::KIND_STATUS && keyword_hit && COUNT_BITS <= 16)
      |-> (keyword_total != '0))
    else $error("counted keyword shows zero total");

  a_report_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPORT && out_load && rep_last) |=> (state == ST_RUN && last))
    else $error("report did not end on last entry");
`endif

endmodule

>>> src/c_keyword_counter.sv
// ----------------------------------------------------------------------------
// c_keyword_counter
// Counts the C keywords in a stream of source characters.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one character per item in ch; with
// end_of_text set, ch is ignored and the pending word is flushed.
// Output channel (out_valid/out_ready): every character item gives one
// status result (kind 0) with the lexer mode and, when a word just ended
// on a keyword, its index and updated count. An end item gives 32 report
// entries (kind 1), one per keyword in alphabetical order, last on the final.
// Each result passes through the command queue and then the result register
// after its item is accepted; a report gives one entry per cycle while out_ready is high.
// Character items are taken one per cycle while the queue is not full; an end item
// holds the count unit while it walks the 32-entry count table.
// A four-entry command queue separates the lexer from the count unit, so
// input keeps flowing while the receiver stalls until the queue fills.
// Reset (rst, synchronous) clears the mode, the pending word and all counts.
// ----------------------------------------------------------------------------
module c_keyword_counter #(
  parameter int MAX_WORD_CHARS = ckc_pkg::DEF_MAX_WORD_CHARS,
  parameter int COUNT_BITS     = ckc_pkg::DEF_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic        keyword_hit,
  output logic [4:0]  keyword_index,
  output logic [15:0] keyword_total,
  output logic [1:0]  lex_mode,
  output logic        last
);

  ckc_pkg::cmd_t push_data, pop_data;
  logic          push, pop, full, empty;

  ckc_lexer #(
    .MAX_WORD_CHARS(MAX_WORD_CHARS)
  ) u_lexer (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ch         (ch),
    .end_of_text(end_of_text),
    .q_full     (full),
    .q_push     (push),
    .q_data     (push_data)
  );

  ckc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (full),
    .pop      (pop),
    .pop_data (pop_data),
    .empty    (empty)
  );

  ckc_tally #(
    .COUNT_BITS(COUNT_BITS)
  ) u_tally (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (empty),
    .q_data       (pop_data),
    .q_pop        (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .keyword_hit  (keyword_hit),
    .keyword_index(keyword_index),
    .keyword_total(keyword_total),
    .lex_mode     (lex_mode),
    .last         (last)
  );

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives C source characters and end items into c_keyword_counter and checks
// every status and report entry against a cycle-free keyword counting
// predictor. Stimulus is a short directed run, a pass that repeats one
// keyword many times, then random token streams. Both channels idle in random
// bursts, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          STALL_LIMIT  = 2000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          REPEAT_HITS  = 20;
  localparam int          RANDOM_ITEMS = 260;
  localparam int          TAIL_ITEMS   = 80;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          SHOW_LIMIT   = 10;
  localparam logic [15:0] TALLY_MAX    = 16'hffff;

  typedef struct packed {
    logic [7:0] code;
    logic       stop;
  } char_item_t;

  typedef struct packed {
    logic       kind;
    logic       hit;
    logic [4:0] idx;
    logic [15:0] total;
    logic [1:0] mode;
    logic       last;
  } entry_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  ch = 8'd0;
  logic        end_of_text = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic        keyword_hit;
  logic [4:0]  keyword_index;
  logic [15:0] keyword_total;
  logic [1:0]  lex_mode;
  logic        last;

  c_keyword_counter dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .ch            (ch),
    .end_of_text   (end_of_text),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .keyword_hit   (keyword_hit),
    .keyword_index (keyword_index),
    .keyword_total (keyword_total),
    .lex_mode      (lex_mode),
    .last          (last)
  );

  char_item_t source_q[$];
  entry_t     entries_due[$];
  char_item_t next_item;

  // lexer and count state mirrored by the predictor
  logic [1:0]  lx_mode;
  logic        mark;
  logic [63:0] word_bits;
  int          word_len;
  logic        word_long;
  logic [15:0] tally [ckc_pkg::NUM_KEYS];

  int n_items = 0;
  int n_ends = 0;
  int n_results = 0;
  int n_hits = 0;
  int n_errors = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  bit hold_done = 1'b0;
  bit in_took = 1'b0;
  bit tail_phase = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_ident(input logic [7:0] c);
    return is_alpha(c) || (c >= "0" && c <= "9") || c == ckc_pkg::CH_UNDER;
  endfunction

  // match the pending word, bump its count, drop the word
  function automatic int close_word();
    int found;
    found = -1;
    if (word_len > 0 && !word_long) begin
      for (int k = 0; k < ckc_pkg::NUM_KEYS; k++) begin
        if (found < 0 && word_bits == ckc_pkg::KEY_TEXT[k]) found = k;
      end
    end
    if (found >= 0 && tally[found] != TALLY_MAX) tally[found] = tally[found] + 16'd1;
    word_len  = 0;
    word_long = 1'b0;
    return found;
  endfunction

  task automatic forecast_keyword_entries(input logic [7:0] c, input logic eot);
    int     hit;
    entry_t e;
    hit = -1;
    if (eot) begin
      hit  = close_word();
      mark = 1'b0;
      for (int k = 0; k < ckc_pkg::NUM_KEYS; k++) begin
        e.kind  = ckc_pkg::KIND_REPORT;
        e.hit   = (hit == k);
        e.idx   = 5'(k);
        e.total = tally[k];
        e.mode  = lx_mode;
        e.last  = (k == ckc_pkg::NUM_KEYS - 1);
        entries_due.push_back(e);
      end
    end else begin
      if (lx_mode == ckc_pkg::MODE_NORMAL && word_len > 0 && is_ident(c)) begin
        if (word_len < ckc_pkg::DEF_MAX_WORD_CHARS) begin
          word_bits = {word_bits[55:0], c};
          word_len++;
        end else begin
          word_long = 1'b1;
        end
      end else begin
        if (word_len > 0) hit = close_word();
        if (lx_mode == ckc_pkg::MODE_NORMAL && is_alpha(c)) begin
          word_bits = {56'd0, c};
          word_len  = 1;
        end
      end
      case (lx_mode)
        ckc_pkg::MODE_NORMAL: begin
          if (mark && c == ckc_pkg::CH_STAR) begin
            lx_mode = ckc_pkg::MODE_COMMENT;
            mark    = 1'b0;
          end else begin
            if (c == ckc_pkg::CH_QUOTE) lx_mode = ckc_pkg::MODE_STRING;
            else if (c == ckc_pkg::CH_HASH) lx_mode = ckc_pkg::MODE_PREP;
            mark = (c == ckc_pkg::CH_SLASH);
          end
        end
        ckc_pkg::MODE_STRING: begin
          if (c == ckc_pkg::CH_QUOTE) lx_mode = ckc_pkg::MODE_NORMAL;
          mark = 1'b0;
        end
        ckc_pkg::MODE_COMMENT: begin
          if (mark && c == ckc_pkg::CH_SLASH) begin
            lx_mode = ckc_pkg::MODE_NORMAL;
            mark    = 1'b0;
          end else begin
            mark = (c == ckc_pkg::CH_STAR);
          end
        end
        default: begin
          if (c == ckc_pkg::CH_NL) lx_mode = ckc_pkg::MODE_NORMAL;
          mark = 1'b0;
        end
      endcase
      e.kind  = ckc_pkg::KIND_STATUS;
      e.hit   = (hit >= 0);
      e.idx   = 5'd0;
      e.total = 16'd0;
      if (hit >= 0) begin
        e.idx   = 5'(hit);
        e.total = tally[hit];
      end
      e.mode = lx_mode;
      e.last = 1'b1;
      entries_due.push_back(e);
    end
  endtask

  task automatic put_byte(input logic [7:0] c);
    char_item_t it;
    it.code = c;
    it.stop = 1'b0;
    source_q.push_back(it);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_end(input logic [7:0] c);
    char_item_t it;
    it.code = c;
    it.stop = 1'b1;
    source_q.push_back(it);
  endtask

  task automatic put_keyword(input int k);
    logic [63:0] w;
    w = ckc_pkg::KEY_TEXT[k];
    for (int j = 7; j >= 0; j--) begin
      if (w[8*j +: 8] != 8'h00) put_byte(w[8*j +: 8]);
    end
  endtask

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] pick_ident_char();
    int r;
    r = $urandom_range(0, 15);
    if (r < 11) return pick_letter();
    if (r < 15) return 8'("0" + $urandom_range(0, 9));
    return ckc_pkg::CH_UNDER;
  endfunction

  task automatic put_separator();
    string seps;
    seps = " ;,()\n\t*/+{}=";
    put_byte(seps[$urandom_range(0, seps.len() - 1)]);
  endtask

  task automatic put_random_token();
    int    sel;
    string body;
    sel  = $urandom_range(0, 19);
    body = "ab \\*/if#\"x\n";
    if (sel <= 5) begin
      put_keyword($urandom_range(0, ckc_pkg::NUM_KEYS - 1));
      put_separator();
    end else if (sel == 6) begin
      // keyword with a tail, no match or too long
      put_keyword($urandom_range(0, ckc_pkg::NUM_KEYS - 1));
      repeat ($urandom_range(1, 4)) put_byte(pick_ident_char());
      put_separator();
    end else if (sel <= 8) begin
      put_byte(pick_letter());
      repeat ($urandom_range(0, 11)) put_byte(pick_ident_char());
      put_separator();
    end else if (sel == 9) begin
      // digits or underscore then letters start a new word
      repeat ($urandom_range(1, 3))
        put_byte(($urandom_range(0, 3) == 0) ? ckc_pkg::CH_UNDER :
                                               8'("0" + $urandom_range(0, 9)));
      if ($urandom_range(0, 1)) put_keyword($urandom_range(0, ckc_pkg::NUM_KEYS - 1));
      put_separator();
    end else if (sel <= 11) begin
      put_byte(ckc_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 3) == 0) put_keyword($urandom_range(0, ckc_pkg::NUM_KEYS - 1));
        else put_byte(body[$urandom_range(0, body.len() - 3)]);
      end
      put_byte(ckc_pkg::CH_QUOTE);
    end else if (sel == 12) begin
      put_byte(ckc_pkg::CH_SLASH);
      put_byte(ckc_pkg::CH_STAR);
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 3) == 0) put_keyword($urandom_range(0, ckc_pkg::NUM_KEYS - 1));
        else put_byte(body[$urandom_range(0, body.len() - 1)]);
      end
      put_byte(ckc_pkg::CH_STAR);
      put_byte(ckc_pkg::CH_SLASH);
    end else if (sel == 13) begin
      put_byte(ckc_pkg::CH_HASH);
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 2) == 0) put_keyword($urandom_range(0, ckc_pkg::NUM_KEYS - 1));
        else put_byte(body[$urandom_range(0, body.len() - 2)]);
      end
      put_byte(ckc_pkg::CH_NL);
    end else if (sel <= 15) begin
      repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
    end else if (sel == 16) begin
      put_end(8'($urandom_range(0, 255)));
    end else begin
      put_separator();
    end
  endtask

  // sender: one item per handshake, idle bursts between items
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (!tail_phase && ((n_items / 100) % 3) != 2 && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 10);
        in_valid <= 1'b0;
      end else if (source_q.size() > 0) begin
        next_item = source_q.pop_front();
        in_valid    <= 1'b1;
        ch          <= next_item.code;
        end_of_text <= next_item.stop;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: idle bursts plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && n_results >= 150) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else if (!tail_phase && ((n_results / 100) % 3) != 1 &&
                 $urandom_range(0, 9) == 0) begin
      recv_gap = $urandom_range(0, 10);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // predict on accepted items, check accepted entries
  always @(posedge clk) begin
    entry_t got;
    entry_t want;
    if (rst) begin
      lx_mode   = ckc_pkg::MODE_NORMAL;
      mark      = 1'b0;
      word_bits = 64'd0;
      word_len  = 0;
      word_long = 1'b0;
      foreach (tally[k]) tally[k] = 16'd0;
      in_took    = 1'b0;
      tail_phase = 1'b0;
    end else begin
      in_took = in_valid && in_ready;
      if (in_took) begin
        forecast_keyword_entries(ch, end_of_text);
        n_items++;
        if (end_of_text) n_ends++;
      end
      if (out_valid && out_ready) begin
        got = '{kind, keyword_hit, keyword_index, keyword_total, lex_mode, last};
        n_results++;
        if (keyword_hit) n_hits++;
        if (entries_due.size() == 0) begin
          n_errors++;
          if (n_errors <= SHOW_LIMIT)
            $display("unexpected entry: kind %0d hit %0d idx %0d total %0d mode %0d last %0d",
                     got.kind, got.hit, got.idx, got.total, got.mode, got.last);
        end else begin
          want = entries_due.pop_front();
          if (got !== want) begin
            n_errors++;
            if (n_errors <= SHOW_LIMIT) begin
              $display("entry %0d mismatch (exp/got): kind %0d/%0d hit %0d/%0d idx %0d/%0d",
                       n_results, want.kind, got.kind, want.hit, got.hit, want.idx, got.idx);
              $display("  total %0d/%0d mode %0d/%0d last %0d/%0d",
                       want.total, got.total, want.mode, got.mode, want.last, got.last);
            end
          end
        end
      end
      tail_phase = (source_q.size() < TAIL_ITEMS);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles > STALL_LIMIT) begin
      $display("no handshake for %0d cycles, %0d entries outstanding",
               STALL_LIMIT, entries_due.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int base;
    // letter after digit, top byte ends a word
    put_text("9if");
    put_byte(8'hff);
    // backslash does not escape a quote, then keyword before a comment
    put_text("\"\\\"do");
    // opener star does not close, keyword inside comment
    put_text("/*/if*/");
    // quote and comment opener inside a preprocessor line
    put_text("#\"/*\n");
    // too long word flushed by an end item
    put_text("continuex");
    put_end(8'h00);
    // keyword flushed by an end item, zero byte ends nothing pending
    put_byte(8'h00);
    put_text("case");
    put_end(8'hff);
    // one keyword counted many times in a row
    for (int i = 0; i < REPEAT_HITS; i++) put_text("do;");
    put_end(8'h5a);
    base = source_q.size();
    while (source_q.size() - base < RANDOM_ITEMS) put_random_token();
    put_end(8'($urandom_range(0, 255)));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (source_q.size() != 0 || in_valid) @(posedge clk);
    while (entries_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items (%0d end items) giving %0d entries with %0d keyword hits",
             n_items, n_ends, n_results, n_hits);
    $display("strings, comments, preprocessor lines, long words, repeated keyword; %0d mismatches",
             n_errors);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
src/ckc_pkg.sv
src/ckc_lexer.sv
src/ckc_queue.sv
src/ckc_tally.sv
src/c_keyword_counter.sv
sim/testbench.sv
